// File: sv/bfm_pkg.sv
`timescale 1ns / 1ps

package bfm_pkg;

    localparam int PIX_W       = 8;
    localparam int SIZE_W      = 6;
    localparam int COL_SUM_W   = 10;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_SHIFT = 14;

    localparam logic [RECIP_W-1:0] RECIP_4 = 13'd4096;
    localparam logic [RECIP_W-1:0] RECIP_6 = 13'd2731;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd1821;

    typedef enum logic [1:0] {
        CNT_4,
        CNT_6,
        CNT_9
    } t_cnt;

    typedef enum logic [1:0] {
        ST_PIX,
        ST_EDGE,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] m;
        logic [PIX_W-1:0] l;
    } t_col;

    typedef struct packed {
        logic l_ok;
        logic r_ok;
        logic use_u;
        logic run_last;
        logic frame_last;
    } t_win_ctl;

    function automatic logic [RECIP_W-1:0] recip(input t_cnt cnt);
        logic [RECIP_W-1:0] k;
        unique case (cnt)
            CNT_4:   k = RECIP_4;
            CNT_6:   k = RECIP_6;
            CNT_9:   k = RECIP_9;
            default: k = RECIP_4;
        endcase
        return k;
    endfunction

endpackage

// File: sv/bfm_pix_if.sv
`timescale 1ns / 1ps

interface bfm_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bfm_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: sv/bfm_res_if.sv
`timescale 1ns / 1ps

interface bfm_res_if;
    logic                      valid;
    logic                      ready;
    logic [bfm_pkg::PIX_W-1:0] pixel_out;
    logic                      run_last;
    logic                      frame_last;

    modport source (output valid, output pixel_out, output run_last, output frame_last,
                    input ready);
    modport sink   (input valid, input pixel_out, input run_last, input frame_last,
                    output ready);
endinterface

// File: sv/bfm_cell.sv
`timescale 1ns / 1ps

module bfm_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  bfm_pkg::t_col i_col,
    output bfm_pkg::t_col o_col
);

    bfm_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

// File: sv/bfm_mean.sv
`timescale 1ns / 1ps

module bfm_mean (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  bfm_pkg::t_col     i_left,
    input  bfm_pkg::t_col     i_ctr,
    input  bfm_pkg::t_col     i_right,
    input  bfm_pkg::t_win_ctl i_ctl,
    output logic              o_ready,
    bfm_res_if.source         o_res
);

    logic                            w_s2_free;
    logic                            w_s1_free;
    logic [bfm_pkg::COL_SUM_W-1:0]   w_sum_l;
    logic [bfm_pkg::COL_SUM_W-1:0]   w_sum_c;
    logic [bfm_pkg::COL_SUM_W-1:0]   w_sum_r;
    logic [bfm_pkg::SUM_W-1:0]       n_sum;
    bfm_pkg::t_cnt                   n_cnt;
    logic [bfm_pkg::PROD_W-1:0]      w_prod;

    logic                            r_s1_valid;
    logic [bfm_pkg::SUM_W-1:0]       r_s1_sum;
    bfm_pkg::t_cnt                   r_s1_cnt;
    logic                            r_s1_run;
    logic                            r_s1_frame;

    logic                            r_s2_valid;
    logic [bfm_pkg::PIX_W-1:0]       r_pix;
    logic                            r_run;
    logic                            r_frame;

    function automatic logic [bfm_pkg::COL_SUM_W-1:0] col_sum(input bfm_pkg::t_col c,
                                                             input logic use_u);
        logic [bfm_pkg::COL_SUM_W-1:0] s;
        s = bfm_pkg::COL_SUM_W'(c.m) + bfm_pkg::COL_SUM_W'(c.l);
        if (use_u) begin
            s = s + bfm_pkg::COL_SUM_W'(c.u);
        end
        return s;
    endfunction

    assign w_s2_free = !r_s2_valid || o_res.ready;
    assign w_s1_free = !r_s1_valid || w_s2_free;
    assign o_ready   = w_s1_free;

    always_comb begin
        w_sum_c = col_sum(i_ctr, i_ctl.use_u);
        w_sum_l = i_ctl.l_ok ? col_sum(i_left, i_ctl.use_u) : '0;
        w_sum_r = i_ctl.r_ok ? col_sum(i_right, i_ctl.use_u) : '0;
        n_sum   = bfm_pkg::SUM_W'(w_sum_c) + bfm_pkg::SUM_W'(w_sum_l)
                + bfm_pkg::SUM_W'(w_sum_r);
        if (i_ctl.l_ok && i_ctl.r_ok && i_ctl.use_u) begin
            n_cnt = bfm_pkg::CNT_9;
        end else if ((i_ctl.l_ok && i_ctl.r_ok) || i_ctl.use_u) begin
            n_cnt = bfm_pkg::CNT_6;
        end else begin
            n_cnt = bfm_pkg::CNT_4;
        end
    end

    assign w_prod = bfm_pkg::PROD_W'(r_s1_sum) * bfm_pkg::PROD_W'(bfm_pkg::recip(r_s1_cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1_sum   <= n_sum;
            r_s1_cnt   <= n_cnt;
            r_s1_run   <= i_ctl.run_last;
            r_s1_frame <= i_ctl.frame_last;
        end
        if (w_s2_free) begin
            r_pix   <= w_prod[bfm_pkg::RECIP_SHIFT +: bfm_pkg::PIX_W];
            r_run   <= r_s1_run;
            r_frame <= r_s1_frame;
        end
    end

    assign o_res.valid      = r_s2_valid;
    assign o_res.pixel_out  = r_pix;
    assign o_res.run_last   = r_run;
    assign o_res.frame_last = r_frame;

endmodule

// File: sv/box_filter_3x3_edge_mean_unit.sv
`timescale 1ns / 1ps
// 3x3 edge-aware box filter over a square image streamed in row-major order.
// i_pix: one 8-bit pixel per beat (valid/ready). o_res: smoothed pixels per beat,
// in row-major order, with run_last on the last result of an input pixel and
// frame_last on the final pixel of the frame.
// i_image_size_we/i_image_size: set the image side (clamped to 2..MAX_SIZE);
// a write also restarts the frame at row 0, column 0. Write only while idle.
// Throughput: one pixel per cycle unless the result stages stall; a pixel
// on the last column of rows 1 and up is followed by a right-edge result
// that takes no pixel, and the last pixel of the frame by a flush of the
// bottom row. This follows from the column ring: a chain of MAX_SIZE cells
// that advances one column per cycle while it shifts, and whose single tap
// feeds one window. A result passes two registered stages after the pixel
// or flush step that produced it (window sum stage, then reciprocal multiply
// into the output register). Reset: counters clear, size returns to 8,
// pipeline empties; the row storage is not cleared. When the receiver stalls,
// the two result stages fill and then i_pix.ready drops until a beat is taken.
module box_filter_3x3_edge_mean_unit #(
    parameter int MAX_SIZE = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_image_size_we,
    input  logic [bfm_pkg::SIZE_W-1:0] i_image_size,
    bfm_pix_if.sink                    i_pix,
    bfm_res_if.source                  o_res
);

    localparam int CW    = $clog2(MAX_SIZE);
    localparam int RST_N = (8 > MAX_SIZE) ? MAX_SIZE : 8;

    bfm_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_x, n_x;
    logic [CW-1:0]      r_last, n_last;
    logic               r_use_u, n_use_u;
    logic               r_flush, n_flush;

    bfm_pkg::t_col      w_cell [MAX_SIZE];
    bfm_pkg::t_col      w_head;
    bfm_pkg::t_col      w_tap;
    bfm_pkg::t_col      w_right;
    bfm_pkg::t_win_ctl  w_ctl;
    logic               w_shift;
    logic               w_win_valid;
    logic               w_mean_ready;
    logic               w_accept;
    logic [6:0]         w_size;

    assign w_tap    = w_cell[r_last];
    assign w_accept = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == bfm_pkg::ST_PIX) && w_mean_ready;

    always_comb begin
        if (i_image_size < bfm_pkg::SIZE_W'(2)) begin
            w_size = 7'd2;
        end else if (int'(i_image_size) > MAX_SIZE) begin
            w_size = 7'(MAX_SIZE);
        end else begin
            w_size = 7'(i_image_size);
        end
    end

    genvar j;
    generate
        for (j = 0; j < MAX_SIZE; j++) begin : g_ring
            if (j == 0) begin : g_head
                bfm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_col   (w_head),
                    .o_col   (w_cell[j])
                );
            end else begin : g_body
                bfm_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_shift),
                    .i_col   (w_cell[j-1]),
                    .o_col   (w_cell[j])
                );
            end
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_col       = r_col;
        n_x         = r_x;
        n_last      = r_last;
        n_use_u     = r_use_u;
        n_flush     = r_flush;
        w_shift     = 1'b0;
        w_win_valid = 1'b0;
        w_head      = '{u: w_tap.m, m: w_tap.l, l: i_pix.pixel_in};
        w_right     = w_tap;
        w_ctl       = '0;

        unique case (r_state)
            bfm_pkg::ST_PIX: begin
                w_right          = '{u: w_tap.m, m: w_tap.l, l: i_pix.pixel_in};
                w_ctl.l_ok       = (r_col != CW'(1));
                w_ctl.r_ok       = 1'b1;
                w_ctl.use_u      = (r_row > CW'(1));
                w_ctl.run_last   = (r_col != r_last);
                w_ctl.frame_last = 1'b0;
                if (w_accept) begin
                    w_shift     = 1'b1;
                    w_win_valid = (r_row != '0) && (r_col != '0);
                    if (r_col == r_last) begin
                        n_col = '0;
                        n_row = (r_row == r_last) ? '0 : r_row + CW'(1);
                        if (r_row != '0) begin
                            n_state = bfm_pkg::ST_EDGE;
                            n_use_u = (r_row > CW'(1));
                            n_flush = (r_row == r_last);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                end
            end
            bfm_pkg::ST_EDGE: begin
                w_head           = w_tap;
                w_ctl.l_ok       = 1'b1;
                w_ctl.r_ok       = 1'b0;
                w_ctl.use_u      = r_use_u;
                w_ctl.run_last   = !r_flush;
                w_ctl.frame_last = 1'b0;
                if (w_mean_ready) begin
                    w_win_valid = 1'b1;
                    w_shift     = r_flush;
                    n_x         = '0;
                    n_state     = r_flush ? bfm_pkg::ST_FLUSH : bfm_pkg::ST_PIX;
                end
            end
            bfm_pkg::ST_FLUSH: begin
                w_head           = w_tap;
                w_ctl.l_ok       = (r_x != '0);
                w_ctl.r_ok       = (r_x != r_last);
                w_ctl.use_u      = 1'b0;
                w_ctl.run_last   = (r_x == r_last);
                w_ctl.frame_last = (r_x == r_last);
                if (w_mean_ready) begin
                    w_win_valid = 1'b1;
                    w_shift     = 1'b1;
                    if (r_x == r_last) begin
                        n_state = bfm_pkg::ST_PIX;
                    end else begin
                        n_x = r_x + CW'(1);
                    end
                end
            end
            default: begin
                n_state = bfm_pkg::ST_PIX;
            end
        endcase

        if (i_image_size_we) begin
            n_last  = CW'(w_size - 7'd1);
            n_row   = '0;
            n_col   = '0;
            n_state = bfm_pkg::ST_PIX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfm_pkg::ST_PIX;
            r_row   <= '0;
            r_col   <= '0;
            r_x     <= '0;
            r_last  <= CW'(RST_N - 1);
            r_use_u <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_x     <= n_x;
            r_last  <= n_last;
            r_use_u <= n_use_u;
            r_flush <= n_flush;
        end
    end

    bfm_mean u_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_win_valid),
        .i_left  (w_cell[1]),
        .i_ctr   (w_cell[0]),
        .i_right (w_right),
        .i_ctl   (w_ctl),
        .o_ready (w_mean_ready),
        .o_res   (o_res)
    );

endmodule
